// ===== hdl/tks_pkg.sv =====
// Shared types and helpers for the top-k smallest selector.
// No dependencies; used by tks_ctrl, tks_datapath and top_k_smallest_selector.
`default_nettype none

package tks_pkg;

  localparam int DIST_W  = 32;
  localparam int ID_W    = 32;
  localparam int KEEP_W  = 7;
  localparam int RANK_W  = 6;
  localparam int IN_DW   = 64;
  localparam int OUT_DW  = 72;

  localparam logic [KEEP_W-1:0] KEEP_RST = 7'd10;

  localparam logic KIND_CAND   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
  } entry_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic ins;  // sorted insert of the input entry
    logic pop;  // shift the chain toward rank 0
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic repl_ok;  // input distance below the largest held entry's distance
  } dp_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // Pair order: signed distance first, then unsigned id.
  function automatic logic pair_less(entry_t a, entry_t b);
    logic dl;
    dl = $signed(a.distance) < $signed(b.distance);
    return dl || ((a.distance == b.distance) && (a.id < b.id));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tks_datapath.sv =====
// Sorted register chain for the top-k selector: one cell per kept entry.
// Depends on tks_pkg.
`default_nettype none

module tks_datapath #(
  parameter int MAX_KEEP = 64,
  parameter int CNT_W    = $clog2(MAX_KEEP + 1)
) (
  input  wire                    clk,
  input  tks_pkg::dp_cmd_t       cmd,
  input  wire  [CNT_W-1:0]       count,
  input  tks_pkg::entry_t        new_entry,
  output tks_pkg::dp_sts_t       sts,
  output tks_pkg::entry_t        head
);

  tks_pkg::entry_t cell_r [MAX_KEEP];
  logic [MAX_KEEP-1:0] lt;       // new entry belongs at or before this cell
  logic [MAX_KEEP-1:0] repl_hit;

  genvar i;
  generate
    for (i = 0; i < MAX_KEEP; i++) begin : g_cell
      logic occ;
      logic is_last;
      assign occ     = count > CNT_W'(i);
      assign is_last = count == CNT_W'(i + 1);
      assign lt[i]   = !occ || tks_pkg::pair_less(new_entry, cell_r[i]);
      assign repl_hit[i] = is_last &&
                           ($signed(new_entry.distance) < $signed(cell_r[i].distance));

      always_ff @(posedge clk) begin
        if (cmd.ins) begin
          if (lt[i]) begin
            if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
              cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
            end else begin
              cell_r[i] <= new_entry;
            end
          end
        end else if (cmd.pop) begin
          if (i < MAX_KEEP - 1) begin
            cell_r[i] <= cell_r[(i < MAX_KEEP - 1) ? i + 1 : i];
          end
        end
      end
    end
  endgenerate

  assign sts.repl_ok = |repl_hit;
  assign head        = cell_r[0];

endmodule

`default_nettype wire

// ===== hdl/tks_ctrl.sv =====
// Controller for the top-k selector: keep register, fill count, emit sequencing.
// Depends on tks_pkg.
`default_nettype none

module tks_ctrl #(
  parameter int MAX_KEEP = 64,
  parameter int CNT_W    = $clog2(MAX_KEEP + 1),
  parameter int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire  [tks_pkg::KEEP_W-1:0]   cfg_wr_data,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire                          in_kind,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic                         out_last,
  output logic [IDX_W-1:0]             out_rank,
  input  tks_pkg::dp_sts_t             sts,
  output tks_pkg::dp_cmd_t             cmd,
  output logic [CNT_W-1:0]             count
);

  tks_pkg::state_t             state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            rank_r, rank_nxt;
  logic [tks_pkg::KEEP_W-1:0]  keep_r;
  logic [tks_pkg::KEEP_W-1:0]  k_eff;
  logic                        below_k;
  logic                        in_acc;
  logic                        out_acc;

  assign k_eff   = (keep_r > tks_pkg::KEEP_W'(MAX_KEEP)) ?
                   tks_pkg::KEEP_W'(MAX_KEEP) : keep_r;
  assign below_k = tks_pkg::KEEP_W'(count_r) < k_eff;

  assign in_tready  = state_r == tks_pkg::ST_IDLE;
  assign out_tvalid = state_r == tks_pkg::ST_EMIT;
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign out_last   = count_r == CNT_W'(1);
  assign out_rank   = rank_r;
  assign count      = count_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    cmd       = '0;
    unique case (state_r)
      tks_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == tks_pkg::KIND_CAND) begin
            cmd.ins = below_k || sts.repl_ok;
            if (below_k) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (count_r != '0) begin
            state_nxt = tks_pkg::ST_EMIT;
            rank_nxt  = '0;
          end
        end
      end
      tks_pkg::ST_EMIT: begin
        if (out_acc) begin
          cmd.pop   = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          rank_nxt  = rank_r + IDX_W'(1);
          if (out_last) begin
            state_nxt = tks_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tks_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tks_pkg::ST_IDLE;
      count_r <= '0;
      rank_r  <= '0;
      keep_r  <= tks_pkg::KEEP_RST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rank_r  <= rank_nxt;
      if (cfg_wr_en) begin
        keep_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/top_k_smallest_selector.sv =====
// Top level of the top-k smallest selector: stream ports and configuration.
// Depends on tks_pkg, tks_ctrl and tks_datapath.
`default_nettype none

// Keeps the keep_count smallest (distance, id) candidates seen since the last
// finish, ordered by signed distance and then unsigned id. Candidate beats
// (in_tuser = 0) are taken one per clock while in_tready is high: each one is
// inserted into a sorted chain of MAX_KEEP registered cells, dropping the
// current largest entry once the store is full (a candidate displaces it only
// when its distance is strictly smaller). A finish beat (in_tuser = 1) starts
// the emit phase: the held entries leave in ascending order, rank 0 first,
// one beat per cycle as out_tready allows, tlast on the final one; the chain
// shifts one place toward the head per beat. n held entries therefore take
// n output beats, during which in_tready is low; a finish with an empty
// store emits nothing. keep_count values above MAX_KEEP act as MAX_KEEP;
// zero keeps nothing. Lowering keep_count while entries are held evicts
// nothing. Write keep_count only while the block is idle.

module top_k_smallest_selector #(
  parameter int MAX_KEEP = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // candidate / finish stream
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [tks_pkg::IN_DW-1:0]    in_tdata,   // [31:0] distance, [63:32] candidate_id
  input  wire                          in_tuser,   // [0] kind
  // result stream
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [tks_pkg::OUT_DW-1:0]   out_tdata,  // [31:0] distance, [63:32] id,
                                                   // [69:64] rank, [71:70] zero
  output logic                         out_tlast,
  // keep_count register
  input  wire                          cfg_wr_en,
  input  wire  [tks_pkg::KEEP_W-1:0]   cfg_wr_data
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  tks_pkg::dp_cmd_t  cmd;
  tks_pkg::dp_sts_t  sts;
  tks_pkg::entry_t   new_entry;
  tks_pkg::entry_t   head;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  rank;

  assign new_entry.distance = in_tdata[31:0];
  assign new_entry.id       = in_tdata[63:32];

  tks_ctrl #(
    .MAX_KEEP (MAX_KEEP),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_kind     (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_last    (out_tlast),
    .out_rank    (rank),
    .sts         (sts),
    .cmd         (cmd),
    .count       (count)
  );

  tks_datapath #(
    .MAX_KEEP (MAX_KEEP),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .count     (count),
    .new_entry (new_entry),
    .sts       (sts),
    .head      (head)
  );

  // head of the chain is a register, so the result beat comes straight off flops
  assign out_tdata = {2'b00, tks_pkg::RANK_W'(rank), head.id, head.distance};

endmodule

`default_nettype wire
